>>> rtl/krld_pkg.sv
// krld_pkg: shared types and constants of the keyed rotation line decoder
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package krld_pkg;

    // sizes of the key alphabet and of the letter stack
    localparam int KEY_MAX   = 16;
    localparam int WORD_MAX  = 63;
    localparam int KEY_IDX_W = $clog2(KEY_MAX);
    localparam int LEN_W     = $clog2(KEY_MAX + 1);
    localparam int FILL_W    = $clog2(WORD_MAX + 1);
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;
    localparam int KEY_W     = 8 * (KEY_MAX / 2);

    // configuration register indexes, each at byte address 8 * index
    localparam logic [2:0] REG_KEY_LOW  = 3'd0;
    localparam logic [2:0] REG_KEY_HIGH = 3'd1;
    localparam logic [2:0] REG_KEY_LEN  = 3'd2;
    localparam logic [2:0] REG_SHIFT    = 3'd3;
    localparam logic [2:0] REG_DECODE   = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       chunk_end;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_chunk_end;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic load_sub;
        logic push;
        logic pop_rd;
        logic out_load;
        logic out_sel_pop;
        logic out_last;
    } dp_cmd_t;

    // datapath and top level to controller
    typedef struct packed {
        logic cfg_busy;
        logic decode;
        logic is_letter;
        logic chunk_end;
        logic fill_zero;
        logic fill_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/krld_mod.sv
// krld_mod: reduces the signed shift, negated when decoding, into 0..len-1, one quotient bit a cycle
// depends on krld_pkg
`timescale 1ns / 1ps
`default_nettype none

module krld_mod import krld_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [15:0]          shift_amount,
    input  wire logic                 decode,
    input  wire logic [LEN_W-1:0]     len,
    output logic                      busy,
    output logic [KEY_IDX_W-1:0]      reduced
);

    logic                 busy_reg, busy_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic [15:0]          mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [KEY_IDX_W-1:0] rem_reg, rem_next;
    logic [KEY_IDX_W-1:0] red_reg, red_next;

    logic [16:0]          s_ext;
    logic [16:0]          s_val;
    logic [16:0]          s_mag;
    logic [LEN_W-1:0]     trial;
    logic [LEN_W-1:0]     rem_step;
    logic [LEN_W-1:0]     fixed;

    always_comb begin
        s_ext = {shift_amount[15], shift_amount};
        s_val = decode ? (17'd0 - s_ext) : s_ext;
        s_mag = s_val[16] ? (17'd0 - s_val) : s_val;

        // restoring step: bring down next magnitude bit
        trial    = {rem_reg, mag_reg[15]};
        rem_step = (trial >= len) ? (trial - len) : trial;
        if (len == '0) begin
            fixed = '0;
        end else if (neg_reg && (rem_step != '0)) begin
            fixed = len - rem_step;
        end else begin
            fixed = rem_step;
        end

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        red_next  = red_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 4'd15;
            mag_next  = s_mag[15:0];
            neg_next  = s_val[16];
            rem_next  = '0;
        end else if (busy_reg) begin
            mag_next = {mag_reg[14:0], 1'b0};
            rem_next = rem_step[KEY_IDX_W-1:0];
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0) begin
                busy_next = 1'b0;
                red_next  = fixed[KEY_IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            red_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            red_reg  <= red_next;
        end
        cnt_reg <= cnt_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        rem_reg <= rem_next;
    end

    assign busy    = busy_reg;
    assign reduced = red_reg;

endmodule

`default_nettype wire

>>> rtl/krld_dp.sv
// krld_dp: datapath with input word, key substitution, letter stack and output register
// depends on krld_pkg
`timescale 1ns / 1ps
`default_nettype none

module krld_dp import krld_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire dp_cmd_t              cmd,
    input  wire in_word_t             s_data,
    input  wire logic [KEY_W-1:0]     key_low,
    input  wire logic [KEY_W-1:0]     key_high,
    input  wire logic [LEN_W-1:0]     len,
    input  wire logic [KEY_IDX_W-1:0] reduced,
    output logic                      is_letter,
    output logic                      chunk_end,
    output logic                      fill_zero,
    output logic                      fill_last,
    output logic                      out_free,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_word_t                 m_data
);

    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LZ = 8'h7a;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UZ = 8'h5a;

    in_word_t             in_reg;
    logic [7:0]           c_reg;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [7:0]           rd_reg;
    logic                 m_valid_reg, m_valid_next;
    out_word_t            m_data_reg;

    logic [7:0]           word_mem [WORD_MAX];

    logic [2*KEY_W-1:0]   key_flat;
    logic [7:0]           key_arr [KEY_MAX];
    logic                 found;
    logic [KEY_IDX_W-1:0] hit_idx;
    logic [LEN_W-1:0]     rot_idx;
    logic [7:0]           sub_byte;

    // first matching key slot, then rotate by the reduced shift
    always_comb begin
        key_flat = {key_high, key_low};
        for (int k = 0; k < KEY_MAX; k++) begin
            key_arr[k] = key_flat[8*k +: 8];
        end
        found   = 1'b0;
        hit_idx = '0;
        for (int k = KEY_MAX - 1; k >= 0; k--) begin
            if ((LEN_W'(k) < len) && (key_arr[k] == in_reg.in_byte)) begin
                found   = 1'b1;
                hit_idx = KEY_IDX_W'(k);
            end
        end
        rot_idx = {1'b0, hit_idx} + {1'b0, reduced};
        if (rot_idx >= len) begin
            rot_idx = rot_idx - len;
        end
        sub_byte = found ? key_arr[rot_idx[KEY_IDX_W-1:0]] : in_reg.in_byte;
    end

    always_comb begin
        fill_next = fill_reg;
        if (cmd.push) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (cmd.pop_rd) begin
            fill_next = fill_reg - FILL_W'(1);
        end
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.load_sub) begin
            c_reg <= sub_byte;
        end
        if (cmd.out_load) begin
            m_data_reg.out_byte      <= cmd.out_sel_pop ? rd_reg : c_reg;
            m_data_reg.out_chunk_end <= cmd.out_last;
        end
    end

    // letter stack, top entry at fill - 1
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            word_mem[fill_reg] <= c_reg;
        end
        if (cmd.pop_rd) begin
            rd_reg <= word_mem[fill_reg - FILL_W'(1)];
        end
    end

    assign is_letter = ((c_reg >= CH_LA) && (c_reg <= CH_LZ))
                    || ((c_reg >= CH_UA) && (c_reg <= CH_UZ));
    assign chunk_end = in_reg.chunk_end;
    assign fill_zero = (fill_reg == '0);
    assign fill_last = (fill_reg == FILL_W'(WORD_MAX - 1));
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

`default_nettype wire

>>> rtl/krld_ctrl.sv
// krld_ctrl: sequencing state machine for accept, substitute, push, flush and emit
// depends on krld_pkg
`timescale 1ns / 1ps
`default_nettype none

module krld_ctrl import krld_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t st,
    output dp_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SUB    = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_POP_RD = 3'd3;
    localparam logic [2:0] ST_POP_WR = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       flush_last_reg, flush_last_next;
    logic       after_emit_reg, after_emit_next;

    always_comb begin
        state_next      = state_reg;
        flush_last_next = flush_last_reg;
        after_emit_next = after_emit_reg;
        cmd             = '0;
        s_ready         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = !st.cfg_busy;
                if (s_valid && !st.cfg_busy) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SUB;
                end
            end
            ST_SUB: begin
                cmd.load_sub = 1'b1;
                state_next   = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!st.decode || !st.is_letter) begin
                    // pending letters go out before this word
                    if (!st.fill_zero) begin
                        flush_last_next = 1'b0;
                        after_emit_next = 1'b1;
                        state_next      = ST_POP_RD;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end else begin
                    cmd.push = 1'b1;
                    if (st.fill_last || st.chunk_end) begin
                        flush_last_next = st.chunk_end;
                        after_emit_next = 1'b0;
                        state_next      = ST_POP_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_POP_RD: begin
                cmd.pop_rd = 1'b1;
                state_next = ST_POP_WR;
            end
            ST_POP_WR: begin
                if (st.out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_sel_pop = 1'b1;
                    cmd.out_last    = st.fill_zero && flush_last_reg;
                    if (!st.fill_zero) begin
                        state_next = ST_POP_RD;
                    end else if (after_emit_reg) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = st.chunk_end;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            flush_last_reg <= 1'b0;
            after_emit_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            flush_last_reg <= flush_last_next;
            after_emit_reg <= after_emit_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/keyed_rotation_line_decoder.sv
// keyed_rotation_line_decoder: top level with register file, shift reduction,
// controller and datapath; depends on krld_pkg, krld_mod, krld_ctrl, krld_dp
`timescale 1ns / 1ps
`default_nettype none

// Substitutes each incoming text word through a keyed alphabet of up to 16
// characters (first match in the key wins, rotated by the reduced shift; bytes
// not in the key pass as they are). With decode_mode set the shift is negated
// and every run of ASCII letters comes out reversed: letters are stacked in a
// 63-entry memory and popped when a non-letter, a chunk end or a full stack
// ends the run. An accepted word passes the states accept, substitute and
// decide, plus emit when it is not stacked; each stacked letter then passes
// a pop read and a pop write state, as the stack memory has one registered
// read port. The output register lets the next word be taken while a result
// still waits. After a write to any of the five registers the shift is
// reduced modulo the key length by a bit-serial divider, during which s_ready
// is low. Registers are 64 bits at byte addresses 0x00 key_chars_low, 0x08
// key_chars_high, 0x10 key_length, 0x18 shift_amount, 0x20 decode_mode.
module keyed_rotation_line_decoder import krld_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // text words in
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_word_t          s_data,
    // text words out
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_word_t              m_data,
    // apb register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    // configuration registers
    logic [KEY_W-1:0]     key_low_reg;
    logic [KEY_W-1:0]     key_high_reg;
    logic [LEN_W-1:0]     key_len_reg;
    logic [15:0]          shift_reg;
    logic                 decode_reg;
    logic                 upd_reg;

    logic [2:0]           reg_idx;
    logic                 wr_en;
    logic [LEN_W-1:0]     eff_len;
    logic                 mod_busy;
    logic [KEY_IDX_W-1:0] reduced;

    dp_cmd_t              cmd;
    dp_status_t           st;
    logic                 is_letter;
    logic                 chunk_end;
    logic                 fill_zero;
    logic                 fill_last;
    logic                 out_free;

    assign reg_idx = paddr[ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= LEN_W'(1);
            shift_reg    <= '0;
            decode_reg   <= 1'b1;
            upd_reg      <= 1'b0;
        end else begin
            // restart the shift reduction in the cycle after a write lands
            upd_reg <= wr_en && (reg_idx <= REG_DECODE);
            if (wr_en) begin
                case (reg_idx)
                    REG_KEY_LOW:  key_low_reg  <= pwdata;
                    REG_KEY_HIGH: key_high_reg <= pwdata;
                    REG_KEY_LEN:  key_len_reg  <= pwdata[LEN_W-1:0];
                    REG_SHIFT:    shift_reg    <= pwdata[15:0];
                    REG_DECODE:   decode_reg   <= pwdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_KEY_LOW:  prdata = key_low_reg;
            REG_KEY_HIGH: prdata = key_high_reg;
            REG_KEY_LEN:  prdata = {{(DATA_W-LEN_W){1'b0}}, key_len_reg};
            REG_SHIFT:    prdata = {{(DATA_W-16){1'b0}}, shift_reg};
            REG_DECODE:   prdata = {{(DATA_W-1){1'b0}}, decode_reg};
            default:      prdata = '0;
        endcase
    end

    // key lengths above the alphabet size saturate
    assign eff_len = (key_len_reg > LEN_W'(KEY_MAX)) ? LEN_W'(KEY_MAX) : key_len_reg;

    krld_mod u_mod (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (upd_reg),
        .shift_amount (shift_reg),
        .decode       (decode_reg),
        .len          (eff_len),
        .busy         (mod_busy),
        .reduced      (reduced)
    );

    // status gathered for the controller
    always_comb begin
        st.cfg_busy  = upd_reg || mod_busy;
        st.decode    = decode_reg;
        st.is_letter = is_letter;
        st.chunk_end = chunk_end;
        st.fill_zero = fill_zero;
        st.fill_last = fill_last;
        st.out_free  = out_free;
    end

    krld_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    krld_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .key_low   (key_low_reg),
        .key_high  (key_high_reg),
        .len       (eff_len),
        .reduced   (reduced),
        .is_letter (is_letter),
        .chunk_end (chunk_end),
        .fill_zero (fill_zero),
        .fill_last (fill_last),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

>>> bench/keyed_rotation_line_decoder_tb.sv
// keyed_rotation_line_decoder_tb: self-checking bench for the keyed rotation line decoder
// depends on krld_pkg and keyed_rotation_line_decoder; drives text words and apb writes
`timescale 1ns / 1ps

module keyed_rotation_line_decoder_tb;
    import krld_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int END_WAIT    = 50000;
    // cycles the block may still spend on a word that leaves no output behind
    localparam int IDLE_CYCLES = 12;
    localparam int HOLD_CYCLES = 400;
    // register indexes with nothing behind them
    localparam logic [2:0] REG_NONE  = 3'd5;
    localparam logic [2:0] REG_SPARE = 3'd7;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_word_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_word_t             m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    keyed_rotation_line_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // predictor state: register copies, reduced rotation, letter stack
    // ------------------------------------------------------------------
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [4:0]  key_len_reg;
    logic [15:0] shift_reg;
    logic        decode_reg;
    logic [4:0]  rotation;
    logic [7:0]  letter_stack [WORD_MAX];
    int          stack_fill;
    out_word_t   expected_out [$];

    // bookkeeping for the summary and for pacing
    int   fail_count;
    int   words_in;
    int   words_out;
    int   settings_used;
    int   full_flushes;
    int   cycle_count;
    int   burst_left;
    bit   no_gaps;
    int   stall_mode;
    logic holding;
    event hold_request;

    // key length above KEY_MAX saturates; zero means no substitution
    function automatic int active_len();
        return (key_len_reg > KEY_MAX) ? KEY_MAX : int'(key_len_reg);
    endfunction

    function automatic logic [7:0] key_char(input int k);
        if (k < 8) begin
            return key_lo[8*k +: 8];
        end
        return key_hi[8*(k-8) +: 8];
    endfunction

    // shift reduced once into 0..len-1, negated first when decoding
    function automatic void recompute_rotation();
        int len;
        int s;
        int r;
        len = active_len();
        s = int'($signed(shift_reg));
        if (decode_reg) begin
            s = -s;
        end
        if (len == 0) begin
            rotation = '0;
        end else begin
            r = s % len;
            if (r < 0) begin
                r += len;
            end
            rotation = r[4:0];
        end
    endfunction

    // first match in the key wins; bytes outside the key pass as they are
    function automatic logic [7:0] substitute_char(input logic [7:0] b);
        int len;
        len = active_len();
        for (int i = 0; i < len; i++) begin
            if (key_char(i) == b) begin
                return key_char((i + rotation) % len);
            end
        end
        return b;
    endfunction

    function automatic bit is_ascii_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // pop every pending letter, the chunk flag only on the last one out
    function automatic void flush_stack(input logic is_last);
        out_word_t w;
        while (stack_fill > 0) begin
            stack_fill--;
            w.out_byte      = letter_stack[stack_fill];
            w.out_chunk_end = (stack_fill == 0) ? is_last : 1'b0;
            expected_out.push_back(w);
        end
    endfunction

    // expected output words caused by one accepted input word
    function automatic void predict_word(input logic [7:0] b, input logic ce);
        logic [7:0] c;
        out_word_t  w;
        c = substitute_char(b);
        w.out_byte      = c;
        w.out_chunk_end = ce;
        if (!decode_reg) begin
            // letters left over from decode mode go out first
            flush_stack(1'b0);
            expected_out.push_back(w);
        end else if (is_ascii_letter(c)) begin
            if (stack_fill < WORD_MAX) begin
                letter_stack[stack_fill] = c;
                stack_fill++;
            end
            if (stack_fill >= WORD_MAX) begin
                full_flushes++;
            end
            if (stack_fill >= WORD_MAX || ce) begin
                flush_stack(ce);
            end
        end else begin
            flush_stack(1'b0);
            expected_out.push_back(w);
        end
    endfunction

    function automatic void store_setting(input logic [2:0] idx, input logic [63:0] value);
        bit known;
        known = 1'b1;
        case (idx)
            REG_KEY_LOW:  key_lo      = value;
            REG_KEY_HIGH: key_hi      = value;
            REG_KEY_LEN:  key_len_reg = value[4:0];
            REG_SHIFT:    shift_reg   = value[15:0];
            REG_DECODE:   decode_reg  = value[0];
            default:      known       = 1'b0;
        endcase
        // a write to an unused index changes nothing, not even the rotation
        if (known) begin
            recompute_rotation();
        end
    endfunction

    // ------------------------------------------------------------------
    // clock, watchdog, receiver and output check
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // long receiver hold-off, counted here so the sender keeps pushing meanwhile
    initial begin
        holding = 1'b0;
        forever begin
            @(hold_request);
            holding = 1'b1;
            repeat (HOLD_CYCLES) @(negedge aclk);
            holding = 1'b0;
        end
    end

    // receiver stall pattern, chosen per phase
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holding) begin
                m_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    2:       m_ready <= $urandom_range(0, 1);
                    default: m_ready <= ((cycle_count % 7) >= 3);
                endcase
            end
        end
    end

    // every accepted output word is checked against the oldest expectation
    always @(posedge aclk) begin : check_output
        out_word_t want;
        if (m_valid === 1'b1 && m_ready === 1'b1) begin
            words_out++;
            if (expected_out.size() == 0) begin
                $error("unexpected word: out_byte %02h out_chunk_end %0b",
                       m_data.out_byte, m_data.out_chunk_end);
                fail_count++;
            end else begin
                want = expected_out.pop_front();
                if (m_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte,
                           m_data.out_byte);
                    fail_count++;
                end
                if (m_data.out_chunk_end !== want.out_chunk_end) begin
                    $error("out_chunk_end: expected %0b, got %0b", want.out_chunk_end,
                           m_data.out_chunk_end);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // bursts of random length with random gaps, unless gaps are off
    task automatic pace_sender();
        int gap;
        if (no_gaps) begin
            return;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 10);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic send_word(input logic [7:0] b, input logic ce);
        in_word_t w;
        w.in_byte   = b;
        w.chunk_end = ce;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_word(b, ce);
        words_in++;
        pace_sender();
    endtask

    // drain all expected words, then let a word that only stacks finish
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_out.size() != 0) @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        store_setting(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] len, input logic [15:0] shift,
                             input logic decode);
        settle();
        write_reg(REG_KEY_LOW, lo);
        write_reg(REG_KEY_HIGH, hi);
        write_reg(REG_KEY_LEN, {59'd0, len});
        write_reg(REG_SHIFT, {48'd0, shift});
        write_reg(REG_DECODE, {63'd0, decode});
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] random_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range(65, 90))
                                    : 8'($urandom_range(97, 122));
    endfunction

    function automatic logic [7:0] random_non_letter();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (is_ascii_letter(c));
        return c;
    endfunction

    // half a key: eight characters, mostly letters unless letters_only
    function automatic logic [63:0] random_key_half(input bit letters_only);
        logic [63:0] v;
        for (int k = 0; k < 8; k++) begin
            if (letters_only || $urandom_range(0, 3) != 0) begin
                v[8*k +: 8] = random_letter();
            end else begin
                v[8*k +: 8] = 8'($urandom_range(0, 255));
            end
        end
        return v;
    endfunction

    // text characters lean on the key so substitution actually happens
    function automatic logic [7:0] key_or_letter();
        int         len;
        logic [7:0] c;
        len = active_len();
        if (len > 0 && $urandom_range(0, 3) != 0) begin
            c = key_char($urandom_range(0, len - 1));
        end else begin
            c = random_letter();
        end
        if (c == 8'h00) begin
            c = random_letter();
        end
        return c;
    endfunction

    // words, separators and some noise, roughly n text words long
    task automatic send_text(input int n);
        int   sent;
        int   kind;
        int   len;
        logic ce;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                len = $urandom_range(1, 10);
                ce  = ($urandom_range(0, 5) == 0);
                for (int i = 0; i < len; i++) begin
                    send_word(key_or_letter(), ce && (i == len - 1));
                end
                sent += len;
            end else if (kind <= 8) begin
                send_word(random_non_letter(), $urandom_range(0, 4) == 0);
                sent++;
            end else begin
                send_word(8'($urandom_range(1, 255)), $urandom_range(0, 1));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------

    // reset settings: one zero key character, decode mode, runs reversed
    task automatic test_reset_defaults();
        send_word("a", 1'b0);
        send_word("Z", 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'h01, 1'b1);
        // the stack is empty here, so this letter opens a run and its chunk end flushes it
        send_word("q", 1'b1);
    endtask

    // full 16-character key, largest positive shift, encode only
    task automatic test_encode_extremes();
        configure(64'h4847_4645_4443_4241, 64'h504F_4E4D_4C4B_4A49, 5'd16,
                  16'h7FFF, 1'b0);
        send_word("A", 1'b0);
        send_word("P", 1'b0);
        send_word("m", 1'b0);
        send_word("~", 1'b1);
    endtask

    // most negative shift must be negated exactly in decode mode
    task automatic test_most_negative_shift();
        configure(64'h4847_4645_4443_4241, 64'h504F_4E4D_4C4B_4A49, 5'd15,
                  16'h8000, 1'b1);
        send_word("B", 1'b0);
        send_word("C", 1'b0);
        send_word(" ", 1'b0);
        send_word("D", 1'b1);
    endtask

    // key length zero passes bytes through; lengths above 16 saturate
    task automatic test_key_length_limits();
        configure(64'h4847_4645_4443_4241, 64'h504F_4E4D_4C4B_4A49, 5'd0,
                  16'h0001, 1'b1);
        send_word("A", 1'b1);
        send_word("!", 1'b1);
        configure(64'h4847_4645_4443_4241, 64'h504F_4E4D_4C4B_4A49, 5'd31,
                  16'h0001, 1'b0);
        send_word("P", 1'b1);
        send_word("C", 1'b1);
    endtask

    // a zero key character in use comes out as a zero byte
    task automatic test_zero_key_char();
        configure(64'h0000_0000_0000_7800, 64'h0, 5'd2, 16'hFFFF, 1'b0);
        send_word("x", 1'b1);
        // writes to an unused index must leave every setting alone
        settle();
        write_reg(REG_NONE, {$urandom(), $urandom()});
        write_reg(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word("x", 1'b0);
        send_word(8'h80, 1'b1);
    endtask

    // letters still stacked when decode mode is switched off come out first
    task automatic test_pending_letters();
        configure(64'h0, 64'h0, 5'd1, 16'h0000, 1'b1);
        send_word("h", 1'b0);
        send_word("i", 1'b0);
        settle();
        write_reg(REG_DECODE, 64'd0);
        send_word(".", 1'b1);
    endtask

    // ------------------------------------------------------------------
    // random tests
    // ------------------------------------------------------------------

    // fresh random settings, extremes of length and shift now and then
    task automatic test_random_settings(input int n);
        logic [4:0]  len;
        logic [15:0] shift;
        case ($urandom_range(0, 4))
            0:       len = 5'd1;
            1:       len = 5'd16;
            default: len = 5'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 4))
            0:       shift = 16'h7FFF;
            1:       shift = 16'h8000;
            2:       shift = 16'($signed($urandom_range(0, 40)) - 20);
            default: shift = 16'($urandom_range(0, 65535));
        endcase
        configure(random_key_half(1'b0), random_key_half(1'b0), len, shift,
                  $urandom_range(0, 3) != 0);
        stall_mode = $urandom_range(0, 3);
        no_gaps    = ($urandom_range(0, 4) == 0);
        send_text(n);
        no_gaps = 1'b0;
    endtask

    // letter runs at and beyond the stack depth get cut and reversed early
    task automatic test_overlong_runs();
        configure(random_key_half(1'b1), random_key_half(1'b1), 5'd16,
                  16'($urandom_range(0, 65535)), 1'b1);
        stall_mode = 1;
        for (int i = 0; i < WORD_MAX; i++) begin
            send_word(random_letter(), 1'b0);
        end
        send_word(random_letter(), 1'b1);
        for (int i = 0; i < WORD_MAX + 3; i++) begin
            send_word(random_letter(), i == WORD_MAX + 2);
        end
        send_word(random_non_letter(), 1'b1);
    endtask

    // receiver holds off for a long stretch while words keep coming
    task automatic test_back_pressure(input int n);
        configure(random_key_half(1'b0), random_key_half(1'b0),
                  5'($urandom_range(1, 16)), 16'($urandom_range(0, 65535)), 1'b1);
        stall_mode = 2;
        no_gaps    = 1'b1;
        -> hold_request;
        send_text(n);
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : main_sequence
        int waited;
        // every block input known from time zero
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        stall_mode = 0;
        no_gaps    = 1'b0;
        burst_left = 0;
        fail_count    = 0;
        words_in      = 0;
        words_out     = 0;
        settings_used = 0;
        full_flushes  = 0;

        // predictor copy of the reset state
        key_lo      = '0;
        key_hi      = '0;
        key_len_reg = 5'd1;
        shift_reg   = '0;
        decode_reg  = 1'b1;
        stack_fill  = 0;
        recompute_rotation();

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_encode_extremes();
        test_most_negative_shift();
        test_key_length_limits();
        test_zero_key_char();
        test_pending_letters();

        for (int p = 0; p < 4; p++) begin
            test_random_settings(48);
        end
        test_overlong_runs();
        test_back_pressure(60);

        // drain what is still owed, bounded, then watch for strays
        @(negedge aclk);
        s_valid <= 1'b0;
        waited = 0;
        while (expected_out.size() != 0 && waited < END_WAIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (40) @(posedge aclk);
        if (expected_out.size() != 0) begin
            $error("%0d expected words never arrived", expected_out.size());
            fail_count++;
        end

        $display("covered %0d words in, %0d words out, %0d register settings",
                 words_in, words_out, settings_used);
        $display("%0d letter runs cut at the stack depth, %0d cycles",
                 full_flushes, cycle_count);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
